FILE: design/ffha_pkg.sv
package ffha_pkg;

  localparam int unsigned ArenaBytes   = 16 * 1024;
  localparam int unsigned GranuleBytes = 16;
  localparam int unsigned HeaderBytes  = 32;

  localparam int unsigned NGran = ArenaBytes / GranuleBytes;
  localparam int unsigned HdrG  = (HeaderBytes + GranuleBytes - 1) / GranuleBytes;

  localparam int unsigned GranW = $clog2(NGran);      // index of a granule
  localparam int unsigned HwW   = GranW + 1;          // holds NGran itself
  localparam int unsigned SzW   = GranW;              // payload size in granules
  localparam int unsigned GReqW = 13;                 // rounded request, up to 4096
  localparam int unsigned CurW  = HwW + 1;            // walk pointer with headroom

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic           used;
    logic [SzW-1:0] size;
  } hdr_t;

endpackage

FILE: design/first_fit_heap_allocator_top.sv
// First-fit heap allocator over a 16 KiB arena of 16-byte granules.
// Input channel (in_valid/in_ready): one word carries in_cmd (0 allocate,
// 1 free), in_request_bytes and in_free_offset. Output channel
// (out_valid/out_ready): one word per input word with out_status,
// out_payload_offset and out_remaining_bytes.
// Block headers (size, used mark) live in one 1024-entry synchronous RAM
// with a registered read. An allocate reads headers in address order and
// takes the first free block that fits, split when the rest can hold a
// header and payload; past the last header it appends at the high-water
// mark or reports no space. A free walks the blocks below its header, then
// reads the successor and predecessor headers to merge free neighbours; a
// null or unaligned free is ignored without a walk. The result word turns
// valid in the same cycle in which the next word can be taken. One word is
// worked on at a time; the next is taken once the current one has been
// handed to the output register, so a stalled receiver holds back at most
// one finished word while the next item is already accepted and processed.
// Reset (rst_n low, synchronous) empties the arena: high-water mark and
// free total go to zero; RAM contents need no clearing since only headers
// below the high-water mark are ever read.
module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_request_bytes,
  input  logic [13:0] in_free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [13:0] out_payload_offset,
  output logic [14:0] out_remaining_bytes
);

  localparam int unsigned GranW = ffha_pkg::GranW;
  localparam int unsigned HwW   = ffha_pkg::HwW;
  localparam int unsigned SzW   = ffha_pkg::SzW;
  localparam int unsigned GReqW = ffha_pkg::GReqW;
  localparam int unsigned CurW  = ffha_pkg::CurW;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_F_RD, S_F_STEP, S_F_H, S_F_NX,
    S_F_WR, S_F_PV, S_FIN
  } state_t;

  // header RAM
  ffha_pkg::hdr_t mem [ffha_pkg::NGran];
  ffha_pkg::hdr_t rdata_r;
  logic              rd_en, wr_en;
  logic [GranW-1:0]  rd_addr, wr_addr;
  ffha_pkg::hdr_t    wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  state_t             state_r, state_nxt;
  logic [HwW-1:0]     hw_r, hw_nxt;
  logic [HwW-1:0]     ftot_r, ftot_nxt;     // free payload, granules
  logic [CurW-1:0]    cur_r, cur_nxt;
  logic [CurW-1:0]    prev_r, prev_nxt;
  logic               hprev_r, hprev_nxt;
  logic [GReqW-1:0]   g_r, g_nxt;
  logic [GranW-1:0]   h_r, h_nxt;
  logic [SzW-1:0]     hsz_r, hsz_nxt;
  logic [SzW-1:0]     left_r, left_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [13:0]        res_off_r, res_off_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_st_r, out_st_nxt;
  logic [13:0]        out_off_r, out_off_nxt;
  logic [14:0]        out_rem_r, out_rem_nxt;

  logic [16:0]        req_round;
  logic [CurW-1:0]    cur_step;
  logic [CurW-1:0]    split_at;
  logic [HwW+1:0]     rem_gran;
  logic [13:0]        cur_off;

  assign req_round = ({1'b0, in_request_bytes} + 17'd15) >> 4;
  assign cur_step  = cur_r + CurW'(ffha_pkg::HdrG) + CurW'(rdata_r.size);
  assign split_at  = cur_r + CurW'(ffha_pkg::HdrG) + CurW'(g_r);
  assign rem_gran  = (HwW+2)'(ffha_pkg::NGran) - (HwW+2)'(hw_r) + (HwW+2)'(ftot_r);
  assign cur_off   = {cur_r[9:0] + 10'(ffha_pkg::HdrG), 4'b0000};

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_payload_offset = out_off_r;
  assign out_remaining_bytes = out_rem_r;

  always_comb begin
    state_nxt     = state_r;
    hw_nxt        = hw_r;
    ftot_nxt      = ftot_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    hprev_nxt     = hprev_r;
    g_nxt         = g_r;
    h_nxt         = h_r;
    hsz_nxt       = hsz_r;
    left_nxt      = left_r;
    res_st_nxt    = res_st_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_off_nxt   = out_off_r;
    out_rem_nxt   = out_rem_r;
    rd_en   = 1'b0;
    rd_addr = cur_r[GranW-1:0];
    wr_en   = 1'b0;
    wr_addr = cur_r[GranW-1:0];
    wr_data = '{used: 1'b0, size: '0};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt   = '0;
          prev_nxt  = '0;
          hprev_nxt = 1'b0;
          g_nxt     = req_round[GReqW-1:0];
          h_nxt     = GranW'(in_free_offset[13:4] - 10'(ffha_pkg::HdrG));
          if (in_cmd == ffha_pkg::CMD_ALLOC) begin
            state_nxt = S_A_RD;
          end else if (in_free_offset < 14'(ffha_pkg::HeaderBytes) ||
                       in_free_offset[3:0] != 4'd0) begin
            // null, unaligned or inside the first header
            res_st_nxt  = ffha_pkg::ST_IGNORED;
            res_off_nxt = '0;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        if (cur_r < CurW'(hw_r)) begin
          rd_en     = 1'b1;
          state_nxt = S_A_CHK;
        end else if ((g_r > GReqW'(ffha_pkg::NGran)) ||
                     ((14'(g_r) + 14'(ffha_pkg::HdrG)) >
                      14'(14'(ffha_pkg::NGran) - 14'(hw_r)))) begin
          res_st_nxt  = ffha_pkg::ST_NOSPACE;
          res_off_nxt = '0;
          state_nxt   = S_FIN;
        end else begin
          // append at the high-water mark
          wr_en       = 1'b1;
          wr_addr     = hw_r[GranW-1:0];
          wr_data     = '{used: 1'b1, size: SzW'(g_r)};
          hw_nxt      = HwW'(14'(hw_r) + 14'(ffha_pkg::HdrG) + 14'(g_r));
          res_st_nxt  = ffha_pkg::ST_DONE;
          res_off_nxt = {hw_r[9:0] + 10'(ffha_pkg::HdrG), 4'b0000};
          state_nxt   = S_FIN;
        end
      end
      S_A_CHK: begin
        if (!rdata_r.used && (GReqW'(rdata_r.size) >= g_r)) begin
          left_nxt    = SzW'(GReqW'(rdata_r.size) - g_r);
          ftot_nxt    = ftot_r - HwW'(rdata_r.size);
          res_st_nxt  = ffha_pkg::ST_DONE;
          res_off_nxt = cur_off;
          if (SzW'(GReqW'(rdata_r.size) - g_r) >= SzW'(ffha_pkg::HdrG + 1)) begin
            state_nxt = S_A_SPLIT;
          end else begin
            wr_en     = 1'b1;
            wr_data   = '{used: 1'b1, size: rdata_r.size};
            state_nxt = S_FIN;
          end
        end else begin
          cur_nxt   = cur_step;
          state_nxt = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        // remainder header written here, granted block in S_F_WR's slot below
        wr_en     = 1'b1;
        wr_addr   = split_at[GranW-1:0];
        wr_data   = '{used: 1'b0, size: left_r - SzW'(ffha_pkg::HdrG)};
        ftot_nxt  = ftot_r + HwW'(left_r) - HwW'(ffha_pkg::HdrG);
        hsz_nxt   = SzW'(g_r);
        state_nxt = S_F_WR;
        h_nxt     = cur_r[GranW-1:0];
        hprev_nxt = 1'b0;
      end
      S_F_RD: begin
        if (cur_r < CurW'(hw_r) && cur_r < CurW'(h_r)) begin
          rd_en     = 1'b1;
          state_nxt = S_F_STEP;
        end else if (cur_r != CurW'(h_r) || cur_r >= CurW'(hw_r)) begin
          res_st_nxt  = ffha_pkg::ST_IGNORED;
          res_off_nxt = '0;
          state_nxt   = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = h_r;
          state_nxt = S_F_H;
        end
      end
      S_F_STEP: begin
        prev_nxt  = cur_r;
        hprev_nxt = 1'b1;
        cur_nxt   = cur_step;
        state_nxt = S_F_RD;
      end
      S_F_H: begin
        if (!rdata_r.used) begin
          res_st_nxt  = ffha_pkg::ST_IGNORED;
          res_off_nxt = '0;
          state_nxt   = S_FIN;
        end else begin
          hsz_nxt     = rdata_r.size;
          ftot_nxt    = ftot_r + HwW'(rdata_r.size);
          res_st_nxt  = ffha_pkg::ST_DONE;
          res_off_nxt = '0;
          if ((CurW'(h_r) + CurW'(ffha_pkg::HdrG) + CurW'(rdata_r.size)) < CurW'(hw_r)) begin
            rd_en     = 1'b1;
            rd_addr   = GranW'(CurW'(h_r) + CurW'(ffha_pkg::HdrG) + CurW'(rdata_r.size));
            state_nxt = S_F_NX;
          end else begin
            state_nxt = S_F_WR;
          end
        end
      end
      S_F_NX: begin
        if (!rdata_r.used) begin
          hsz_nxt  = hsz_r + SzW'(ffha_pkg::HdrG) + rdata_r.size;
          ftot_nxt = ftot_r + HwW'(ffha_pkg::HdrG);
        end
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        // shared: freed block header, or granted block after a split
        wr_en   = 1'b1;
        wr_addr = h_r;
        wr_data = '{used: (res_off_r != '0), size: hsz_r};
        if (hprev_r) begin
          rd_en     = 1'b1;
          rd_addr   = prev_r[GranW-1:0];
          state_nxt = S_F_PV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_F_PV: begin
        if (!rdata_r.used) begin
          wr_en    = 1'b1;
          wr_addr  = prev_r[GranW-1:0];
          wr_data  = '{used: 1'b0,
                       size: rdata_r.size + SzW'(ffha_pkg::HdrG) + hsz_r};
          ftot_nxt = ftot_r + HwW'(ffha_pkg::HdrG);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_off_nxt   = res_off_r;
          out_rem_nxt   = 15'({rem_gran, 4'b0000});
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      ftot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      ftot_r      <= ftot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    hprev_r   <= hprev_nxt;
    g_r       <= g_nxt;
    h_r       <= h_nxt;
    hsz_r     <= hsz_nxt;
    left_r    <= left_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    out_st_r  <= out_st_nxt;
    out_off_r <= out_off_nxt;
    out_rem_r <= out_rem_nxt;
  end

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= HwW'(ffha_pkg::NGran))
    else $error("high-water mark beyond arena");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (ftot_r <= hw_r))
    else $error("free total exceeds used arena");

  a_hw_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (hw_r >= $past(hw_r)))
    else $error("high-water mark shrank");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> out_valid_r)
    else $error("finished word not loaded");

endmodule
